[hdl/swsch_pkg.sv]
// shared types and constants of the soil watering scheduler
`default_nettype none

package swsch_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MOISTURE_TARGET = 3'd0,
    CFG_INTERVAL_DAYS   = 3'd1,
    CFG_WATER_VOLUME_ML = 3'd2,
    CFG_DRY_LEVEL       = 3'd3,
    CFG_WET_LEVEL       = 3'd4,
    CFG_LIGHT_LIMIT     = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned FieldW   = 12;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // clock and calendar
  localparam int unsigned MinutesPerHour = 60;
  localparam int unsigned HoursPerDay    = 24;
  localparam int unsigned DayMinutes     = 1440;
  localparam int unsigned DayFirstHour   = 7;
  localparam int unsigned DayEndHour     = 19;

  // light accumulation
  localparam int unsigned MaxLightSamples = 15;

  // moisture scale
  localparam int unsigned FullPercent = 100;
  localparam int unsigned QuotientW   = 7;

  // pump time: (ml*1000 + 35) / 70 equals (100*ml + 3) / 7,
  // the division by 7 done as a multiply by ceil(2^19 / 7) and a shift
  localparam int unsigned PumpScale  = 100;
  localparam int unsigned PumpOffset = 3;
  localparam int unsigned PumpRecip  = 74899;
  localparam int unsigned PumpShift  = 19;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // capture an input transaction
    logic prep;      // moisture class, product, light handling
    logic mul;       // pump product and divider start
    logic div_step;  // one quotient bit
    logic decide;    // watering decision and clock advance
    logic load_out;  // move the result into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // the current divider step is the final one
  } sts_t;

  // one result, first field in the highest bits
  typedef struct packed {
    logic [5:0]  minute_now;
    logic [4:0]  hour_now;
    logic        low_light_alarm;
    logic [14:0] minutes_left;
    logic [12:0] pump_ms;
    logic        water_now;
    logic [6:0]  moisture_percent;
  } res_t;

endpackage

`default_nettype wire

[hdl/swsch_ctrl.sv]
// sequencing state machine and output handshake of the watering scheduler
`default_nettype none

module swsch_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  input  wire swsch_pkg::sts_t sts_i,
  output swsch_pkg::cmd_t    cmd_o
);
  import swsch_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_DECIDE,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == ST_IDLE) && s_axis_tvalid;
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.decide   = (state_q == ST_DECIDE);
    cmd_o.load_out = (state_q == ST_OUT) && out_free;
  end

  // output valid: raised when a result is loaded, dropped when it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP:   state_q <= ST_MUL;
        ST_MUL:    state_q <= ST_DIV;
        ST_DIV: begin
          if (sts_i.div_last) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/swsch_dp.sv]
// datapath of the watering scheduler: settings, clock, light, divider, decision
`default_nettype none

module swsch_dp #(
  parameter int unsigned TICK_MINUTES = 90,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swsch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [swsch_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [swsch_pkg::InDataW-1:0]  in_data_i,
  input  wire swsch_pkg::cmd_t               cmd_i,
  output swsch_pkg::sts_t                    sts_o,
  output swsch_pkg::res_t                    out_o
);
  import swsch_pkg::*;

  localparam int unsigned MaskBits   = (SAMPLE_BITS < FieldW) ? SAMPLE_BITS : FieldW;
  localparam logic [FieldW-1:0] SampleMask = FieldW'((32'd1 << MaskBits) - 32'd1);
  localparam int unsigned TickHours  = TICK_MINUTES / MinutesPerHour;
  localparam int unsigned TickMins   = TICK_MINUTES % MinutesPerHour;
  localparam int unsigned NumW       = 19;

  // settings
  logic [6:0]  target_q;
  logic [3:0]  interval_q;
  logic [8:0]  volume_q;
  logic [11:0] dry_q;
  logic [11:0] wet_q;
  logic [11:0] limit_q;

  // block state
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [15:0] elapsed_q;
  logic [15:0] light_total_q;
  logic [3:0]  light_cnt_q;

  // per transaction working registers
  logic [11:0]     soil_q;
  logic [11:0]     light_q;
  logic            cls_zero_q;
  logic            cls_full_q;
  logic [NumW-1:0] num_q;
  logic [11:0]     den_q;
  logic            alarm_q;
  logic [15:0]     pump_m_q;
  logic [14:0]     needed_q;
  logic [32:0]     pump_prod_q;
  logic [NumW-1:0] rem_q;
  logic [NumW-1:0] dsh_q;
  logic [QuotientW-1:0] quo_q;
  logic [2:0]      div_cnt_q;
  res_t            res_q;
  res_t            out_q;

  // settings write decoder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= 7'd0;
      interval_q <= 4'd1;
      volume_q   <= 9'd50;
      dry_q      <= 12'd4089;
      wet_q      <= 12'd1858;
      limit_q    <= 12'd704;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MOISTURE_TARGET: target_q   <= cfg_data_i[6:0];
        CFG_INTERVAL_DAYS:   interval_q <= cfg_data_i[3:0];
        CFG_WATER_VOLUME_ML: volume_q   <= cfg_data_i[8:0];
        CFG_DRY_LEVEL:       dry_q      <= cfg_data_i;
        CFG_WET_LEVEL:       wet_q      <= cfg_data_i;
        CFG_LIGHT_LIMIT:     limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // light handling
  logic        is_day;
  logic [16:0] light_acc;
  logic [15:0] limit_scaled;
  assign is_day       = (hour_q >= 5'(DayFirstHour)) && (hour_q < 5'(DayEndHour));
  assign light_acc    = {1'b0, light_total_q} + {5'd0, light_q};
  assign limit_scaled = {4'd0, limit_q} * {12'd0, light_cnt_q};

  // divider trial subtraction
  logic            div_ge;
  logic [NumW-1:0] div_diff;
  assign div_ge   = (rem_q >= dsh_q);
  assign div_diff = rem_q - dsh_q;
  assign sts_o.div_last = (div_cnt_q == 3'd0);

  // watering decision
  logic [6:0]  moist;
  logic        dry_soil;
  logic        allowed;
  logic        water;
  logic [16:0] elapsed_base;
  logic [16:0] elapsed_sum;
  assign moist        = cls_zero_q ? 7'd0 : (cls_full_q ? 7'(FullPercent) : quo_q);
  assign dry_soil     = (moist < target_q);
  assign allowed      = (elapsed_q >= {1'b0, needed_q});
  assign water        = dry_soil && allowed;
  assign elapsed_base = water ? 17'd0 : {1'b0, elapsed_q};
  assign elapsed_sum  = elapsed_base + 17'(TICK_MINUTES);

  // clock advance
  logic [6:0] min_sum;
  logic       min_carry;
  logic [5:0] hour_sum;
  assign min_sum   = {1'b0, minute_q} + 7'(TickMins);
  assign min_carry = (min_sum >= 7'(MinutesPerHour));
  assign hour_sum  = {1'b0, hour_q} + 6'(TickHours) + {5'd0, min_carry};

  // block state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q        <= 5'd18;
      minute_q      <= 6'd40;
      elapsed_q     <= 16'd0;
      light_total_q <= 16'd0;
      light_cnt_q   <= 4'd0;
    end else begin
      if (cmd_i.prep) begin
        if (is_day) begin
          if (light_cnt_q < 4'(MaxLightSamples)) begin
            light_total_q <= light_acc[16] ? 16'hFFFF : light_acc[15:0];
            light_cnt_q   <= light_cnt_q + 4'd1;
          end
        end else begin
          light_total_q <= 16'd0;
          light_cnt_q   <= 4'd0;
        end
      end
      if (cmd_i.decide) begin
        elapsed_q <= elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
        minute_q  <= min_carry ? 6'(min_sum - 7'(MinutesPerHour)) : min_sum[5:0];
        hour_q    <= (hour_sum >= 6'(HoursPerDay)) ? 5'(hour_sum - 6'(HoursPerDay))
                                                   : hour_sum[4:0];
      end
    end
  end

  // working registers and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      soil_q  <= in_data_i[11:0] & SampleMask;
      light_q <= in_data_i[23:12] & SampleMask;
    end
    if (cmd_i.prep) begin
      cls_zero_q <= (soil_q >= dry_q);
      cls_full_q <= (soil_q <= wet_q);
      num_q      <= NumW'(dry_q - soil_q) * NumW'(FullPercent);
      den_q      <= dry_q - wet_q;
      alarm_q    <= !is_day && (light_cnt_q != 4'd0) && (light_total_q <= limit_scaled);
      pump_m_q   <= 16'(volume_q) * 16'(PumpScale) + 16'(PumpOffset);
      needed_q   <= 15'(interval_q) * 15'(DayMinutes);
    end
    if (cmd_i.mul) begin
      pump_prod_q <= 33'(pump_m_q) * 33'(PumpRecip);
      rem_q       <= num_q;
      dsh_q       <= NumW'({den_q, 6'd0});
      quo_q       <= '0;
      div_cnt_q   <= 3'(QuotientW - 1);
    end
    // one restoring step per cycle, quotient below 100
    if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= div_diff;
      end
      quo_q     <= {quo_q[QuotientW-2:0], div_ge};
      dsh_q     <= dsh_q >> 1;
      div_cnt_q <= div_cnt_q - 3'd1;
    end
    if (cmd_i.decide) begin
      res_q.moisture_percent <= moist;
      res_q.water_now        <= water;
      res_q.pump_ms          <= water ? pump_prod_q[PumpShift+12:PumpShift] : 13'd0;
      res_q.minutes_left     <= (dry_soil && !allowed) ? (needed_q - elapsed_q[14:0])
                                                       : 15'd0;
      res_q.low_light_alarm  <= alarm_q;
      res_q.hour_now         <= hour_q;
      res_q.minute_now       <= minute_q;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

[hdl/soil_watering_scheduler_core.sv]
// top level of the soil watering scheduler
// sequence: an accepted wake-up passes the prep, multiply, divide, decide and output states;
//   the next one is taken only once the result is loaded, the pace set by the controller with its
//   seven-step restoring divider for the moisture percentage
// a finished result waits in the output register while the next wake-up is taken
// reset: asynchronous active low; settings, clock (18:40) and counters return to defaults
`default_nettype none

module soil_watering_scheduler_core #(
  parameter int unsigned TICK_MINUTES = 90,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // settings write port
  input  wire logic                           cfg_we_i,
  input  wire logic [swsch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [swsch_pkg::CfgDataW-1:0] cfg_data_i,
  // wake-up input
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [swsch_pkg::InDataW-1:0]  s_axis_tdata,  // soil_sample, light_sample
  // result output
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // moisture_percent, water_now, pump_ms, minutes_left, low_light_alarm,
  // hour_now, minute_now
  output logic [swsch_pkg::OutDataW-1:0]      m_axis_tdata
);
  import swsch_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t out;

  swsch_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  swsch_dp #(
    .TICK_MINUTES (TICK_MINUTES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out)
  );

  assign m_axis_tdata = out;

endmodule

`default_nettype wire

[hdl/swsch_chk.sv]
// port-level checks of the watering scheduler and their binding
`default_nettype none

module swsch_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [swsch_pkg::OutDataW-1:0] m_axis_tdata
);
  import swsch_pkg::*;

  res_t r;
  assign r = m_axis_tdata;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one wake-up at a time: input closes after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second wake-up taken back to back");

  // clock and moisture stay in range
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r.moisture_percent <= 7'(FullPercent)) && (r.hour_now < 5'd24)
                      && (r.minute_now < 6'd60))
    else $error("result field out of range");

  // watering and waiting are exclusive
  a_water_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r.water_now ? (r.minutes_left == 15'd0) : (r.pump_ms == 13'd0)))
    else $error("pump time and waiting time disagree with water_now");

endmodule

bind soil_watering_scheduler_core swsch_chk u_swsch_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[verif/tb.sv]
// testbench for the soil watering scheduler core: directed table, then randomised phases
`timescale 1ns / 100ps

module tb;
  import swsch_pkg::*;

  localparam int unsigned TickMinutes = 90;
  localparam int unsigned FlowMlPerS  = 70;
  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned SatMinutes  = 65535;
  localparam int unsigned SampleMax   = 4095;
  localparam int          DirRows     = 33;

  typedef enum logic {ROW_WAKE, ROW_CFG} row_kind_e;

  typedef enum logic [2:0] {
    SET_TOP, SET_BOTTOM, SET_WATERING, SET_DRY_SPELL, SET_CATCH_UP
  } setting_mode_e;

  // one directed step: a wake-up (a soil, b light) or a setting write (a index, b value)
  typedef struct packed {
    row_kind_e   kind;
    logic [11:0] a;
    logic [11:0] b;
    logic        known;
    res_t        want;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  cfg_idx_e            cfg_idx       = CFG_MOISTURE_TARGET;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // soil_sample, light_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // moisture .. minute_now, see res_t

  // settings as the block should hold them
  logic [6:0]  set_target      = 7'd0;
  logic [3:0]  set_interval    = 4'd1;
  logic [8:0]  set_volume      = 9'd50;
  logic [11:0] set_dry         = 12'd4089;
  logic [11:0] set_wet         = 12'd1858;
  logic [11:0] set_light_limit = 12'd704;

  // schedule state as the block should hold it
  int unsigned wk_hour         = 18;
  int unsigned wk_minute       = 40;
  int unsigned elapsed_min     = 0;
  int unsigned day_light_total = 0;
  int unsigned day_light_cnt   = 0;

  res_t        pending_results[$];
  dir_row_t    dir_rows [DirRows];
  int unsigned burst_left     = 0;
  logic [15:0] ready_pattern  = '1;
  int unsigned pattern_life   = 0;
  int unsigned mismatch_count = 0;
  int unsigned wakeups_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned waterings_seen = 0;
  int unsigned alarms_seen    = 0;
  int unsigned phases_run     = 0;

  soil_watering_scheduler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic res_t pack_result(input int unsigned moist, input int unsigned water,
                                       input int unsigned pump, input int unsigned left,
                                       input int unsigned alarm, input int unsigned hour,
                                       input int unsigned minute);
    res_t r;
    r.moisture_percent = 7'(moist);
    r.water_now        = 1'(water);
    r.pump_ms          = 13'(pump);
    r.minutes_left     = 15'(left);
    r.low_light_alarm  = 1'(alarm);
    r.hour_now         = 5'(hour);
    r.minute_now       = 6'(minute);
    return r;
  endfunction

  // one wake-up: light bookkeeping, moisture, watering decision, clock advance
  task automatic predict_wakeup(input logic [11:0] soil, input logic [11:0] light,
                                output res_t r);
    int unsigned soil_v, dry_v, wet_v, moist, needed, carry;
    soil_v = 32'(soil);
    dry_v  = 32'(set_dry);
    wet_v  = 32'(set_wet);
    r = '0;
    r.hour_now   = 5'(wk_hour);
    r.minute_now = 6'(wk_minute);
    // daytime samples accumulate, the first night wake-up judges them
    if (wk_hour >= DayFirstHour && wk_hour < DayEndHour) begin
      if (day_light_cnt < MaxLightSamples) begin
        day_light_total = day_light_total + 32'(light);
        if (day_light_total > SatMinutes) day_light_total = SatMinutes;
        day_light_cnt++;
      end
    end else if (day_light_cnt > 0) begin
      r.low_light_alarm = (day_light_total <= 32'(set_light_limit) * day_light_cnt);
      day_light_total = 0;
      day_light_cnt   = 0;
    end
    // moisture between the dry and wet counts
    if (soil_v >= dry_v) moist = 0;
    else if (soil_v <= wet_v) moist = FullPercent;
    else moist = ((dry_v - soil_v) * FullPercent) / (dry_v - wet_v);
    r.moisture_percent = 7'(moist);
    // water now, or report the wait
    needed = 32'(set_interval) * DayMinutes;
    if (moist < 32'(set_target)) begin
      if (elapsed_min >= needed) begin
        r.water_now = 1'b1;
        r.pump_ms   = 13'((32'(set_volume) * MsPerSecond + FlowMlPerS / 2) / FlowMlPerS);
        elapsed_min = 0;
      end else begin
        r.minutes_left = 15'(needed - elapsed_min);
      end
    end
    // clock and elapsed time move on
    carry       = wk_minute + TickMinutes;
    wk_hour     = (wk_hour + carry / MinutesPerHour) % HoursPerDay;
    wk_minute   = carry % MinutesPerHour;
    elapsed_min = elapsed_min + TickMinutes;
    if (elapsed_min > SatMinutes) elapsed_min = SatMinutes;
  endtask

  // setting write, only while the block is idle
  task automatic write_setting(input cfg_idx_e idx, input logic [11:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx    = idx;
    cfg_data_i = value;
    case (idx)
      CFG_MOISTURE_TARGET: set_target      = value[6:0];
      CFG_INTERVAL_DAYS:   set_interval    = value[3:0];
      CFG_WATER_VOLUME_ML: set_volume      = value[8:0];
      CFG_DRY_LEVEL:       set_dry         = value;
      CFG_WET_LEVEL:       set_wet         = value;
      CFG_LIGHT_LIMIT:     set_light_limit = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // one input transaction, sent in bursts with random gaps
  task automatic send_wakeup(input logic [11:0] soil, input logic [11:0] light,
                             input logic known, input res_t typed);
    res_t        want;
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {light, soil};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_wakeup(soil, light, want);
    if (known) want = typed;
    pending_results.push_back(want);
    wakeups_sent++;
  endtask

  function automatic logic [11:0] pick_soil();
    int v;
    case ($urandom_range(0, 5))
      0: v = ($urandom_range(0, 1) != 0) ? SampleMax : 0;
      1: v = int'(set_dry) + int'($urandom_range(0, 4)) - 2;
      2: v = int'(set_wet) + int'($urandom_range(0, 4)) - 2;
      3: v = (set_wet < set_dry) ? int'($urandom_range(set_wet, set_dry)) : 0;
      default: v = $urandom_range(0, SampleMax);
    endcase
    if (v < 0) v = 0;
    if (v > SampleMax) v = SampleMax;
    return 12'(v);
  endfunction

  function automatic logic [11:0] pick_light();
    int v;
    case ($urandom_range(0, 3))
      0: v = ($urandom_range(0, 1) != 0) ? SampleMax : 0;
      1: v = int'(set_light_limit) + int'($urandom_range(0, 64)) - 32;
      default: v = $urandom_range(0, SampleMax);
    endcase
    if (v < 0) v = 0;
    if (v > SampleMax) v = SampleMax;
    return 12'(v);
  endfunction

  // a full set of settings for one phase
  task automatic choose_settings(input setting_mode_e mode);
    logic [11:0] dry, wet;
    case (mode)
      SET_TOP: begin
        write_setting(CFG_MOISTURE_TARGET, 12'd127);
        write_setting(CFG_INTERVAL_DAYS, 12'd15);
        write_setting(CFG_WATER_VOLUME_ML, 12'd511);
        write_setting(CFG_DRY_LEVEL, 12'd4095);
        write_setting(CFG_WET_LEVEL, 12'd4095);
        write_setting(CFG_LIGHT_LIMIT, 12'd4095);
      end
      SET_BOTTOM: begin
        write_setting(CFG_MOISTURE_TARGET, 12'd0);
        write_setting(CFG_INTERVAL_DAYS, 12'd0);
        write_setting(CFG_WATER_VOLUME_ML, 12'd0);
        write_setting(CFG_DRY_LEVEL, 12'd0);
        write_setting(CFG_WET_LEVEL, 12'd0);
        write_setting(CFG_LIGHT_LIMIT, 12'd0);
      end
      default: begin
        dry = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                          : 12'($urandom_range(2500, 4095));
        wet = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                          : 12'($urandom_range(0, 2000));
        case (mode)
          SET_WATERING: begin
            write_setting(CFG_MOISTURE_TARGET, 12'($urandom_range(30, 127)));
            write_setting(CFG_INTERVAL_DAYS, ($urandom_range(0, 4) == 0) ?
                          12'($urandom_range(4, 15)) : 12'($urandom_range(0, 2)));
          end
          SET_DRY_SPELL: begin
            write_setting(CFG_MOISTURE_TARGET, 12'd0);
            write_setting(CFG_INTERVAL_DAYS, 12'($urandom_range(0, 15)));
          end
          default: begin
            write_setting(CFG_MOISTURE_TARGET, 12'd127);
            write_setting(CFG_INTERVAL_DAYS, 12'($urandom_range(8, 15)));
          end
        endcase
        write_setting(CFG_WATER_VOLUME_ML, 12'($urandom_range(0, 511)));
        write_setting(CFG_DRY_LEVEL, dry);
        write_setting(CFG_WET_LEVEL, wet);
        write_setting(CFG_LIGHT_LIMIT, 12'($urandom_range(0, 4095)));
      end
    endcase
    phases_run++;
  endtask

  // compare one output transaction against the oldest expectation
  task automatic check_result(input res_t got);
    res_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: %h", got);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (want.water_now) waterings_seen++;
    if (want.low_light_alarm) alarms_seen++;
    if (got.moisture_percent !== want.moisture_percent) begin
      $error("moisture_percent: expected %0d, got %0d", want.moisture_percent,
             got.moisture_percent);
      mismatch_count++;
    end
    if (got.water_now !== want.water_now) begin
      $error("water_now: expected %0d, got %0d", want.water_now, got.water_now);
      mismatch_count++;
    end
    if (got.pump_ms !== want.pump_ms) begin
      $error("pump_ms: expected %0d, got %0d", want.pump_ms, got.pump_ms);
      mismatch_count++;
    end
    if (got.minutes_left !== want.minutes_left) begin
      $error("minutes_left: expected %0d, got %0d", want.minutes_left, got.minutes_left);
      mismatch_count++;
    end
    if (got.low_light_alarm !== want.low_light_alarm) begin
      $error("low_light_alarm: expected %0d, got %0d", want.low_light_alarm,
             got.low_light_alarm);
      mismatch_count++;
    end
    if (got.hour_now !== want.hour_now) begin
      $error("hour_now: expected %0d, got %0d", want.hour_now, got.hour_now);
      mismatch_count++;
    end
    if (got.minute_now !== want.minute_now) begin
      $error("minute_now: expected %0d, got %0d", want.minute_now, got.minute_now);
      mismatch_count++;
    end
  endtask

  // output side stalls on a rotating pattern, reloaded whenever pattern_life runs out
  always @(negedge clk_i) begin
    if (pattern_life == 0) begin
      pattern_life  = 40;
      ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
      ready_pattern[$urandom_range(0, 15)] = 1'b1;
    end
    pattern_life--;
    m_axis_tready = ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(res_t'(m_axis_tdata));
  end

  // stimulus
  initial begin
    int ph;
    // directed steps, clock walks from 18:40 in 90 minute ticks
    dir_rows = '{
      '{ROW_WAKE, 12'd4095, 12'd4095, 1'b1, pack_result(0, 0, 0, 0, 0, 18, 40)},
      '{ROW_WAKE, 12'd0,    12'd0,    1'b1, pack_result(100, 0, 0, 0, 0, 20, 10)},
      '{ROW_WAKE, 12'd4089, 12'd0,    1'b1, pack_result(0, 0, 0, 0, 0, 21, 40)},
      '{ROW_WAKE, 12'd1858, 12'd4095, 1'b1, pack_result(100, 0, 0, 0, 0, 23, 10)},
      // target above full scale, no waiting interval
      '{ROW_CFG,  12'(CFG_MOISTURE_TARGET), 12'd127, 1'b0, '0},
      '{ROW_CFG,  12'(CFG_INTERVAL_DAYS),   12'd0,   1'b0, '0},
      '{ROW_WAKE, 12'd4095, 12'd123,  1'b1, pack_result(0, 1, 714, 0, 0, 0, 40)},
      '{ROW_CFG,  12'(CFG_WATER_VOLUME_ML), 12'd511, 1'b0, '0},
      '{ROW_CFG,  12'(CFG_INTERVAL_DAYS),   12'd15,  1'b0, '0},
      '{ROW_WAKE, 12'd3000, 12'd0,    1'b0, '0},
      // dry count below wet count
      '{ROW_CFG,  12'(CFG_DRY_LEVEL),   12'd1000, 1'b0, '0},
      '{ROW_CFG,  12'(CFG_WET_LEVEL),   12'd3000, 1'b0, '0},
      '{ROW_CFG,  12'(CFG_LIGHT_LIMIT), 12'd4095, 1'b0, '0},
      '{ROW_WAKE, 12'd2000, 12'd4095, 1'b0, '0},
      '{ROW_WAKE, 12'd500,  12'd0,    1'b0, '0},
      // dry and wet counts equal
      '{ROW_CFG,  12'(CFG_DRY_LEVEL), 12'd2048, 1'b0, '0},
      '{ROW_CFG,  12'(CFG_WET_LEVEL), 12'd2048, 1'b0, '0},
      '{ROW_WAKE, 12'd2048, 12'd4095, 1'b0, '0},
      '{ROW_WAKE, 12'd2047, 12'd4095, 1'b0, '0},
      // widest span
      '{ROW_CFG,  12'(CFG_DRY_LEVEL), 12'd4095, 1'b0, '0},
      '{ROW_CFG,  12'(CFG_WET_LEVEL), 12'd0,    1'b0, '0},
      '{ROW_WAKE, 12'd1,    12'd4095, 1'b0, '0},
      '{ROW_WAKE, 12'd4094, 12'd4095, 1'b0, '0},
      // pump time at zero and full volume
      '{ROW_CFG,  12'(CFG_INTERVAL_DAYS),   12'd0, 1'b0, '0},
      '{ROW_CFG,  12'(CFG_WATER_VOLUME_ML), 12'd0, 1'b0, '0},
      '{ROW_WAKE, 12'd4095, 12'd4095, 1'b1, pack_result(0, 1, 0, 0, 0, 12, 40)},
      '{ROW_CFG,  12'(CFG_WATER_VOLUME_ML), 12'd511, 1'b0, '0},
      '{ROW_WAKE, 12'd4095, 12'd4095, 1'b1, pack_result(0, 1, 7300, 0, 0, 14, 10)},
      '{ROW_WAKE, 12'd0,    12'd4095, 1'b0, '0},
      '{ROW_WAKE, 12'd2000, 12'd4095, 1'b0, '0},
      '{ROW_WAKE, 12'd3000, 12'd4095, 1'b0, '0},
      // night average exactly at the limit, then a night with nothing pending
      '{ROW_WAKE, 12'd4095, 12'd0,    1'b1, pack_result(0, 1, 7300, 0, 1, 20, 10)},
      '{ROW_WAKE, 12'd4095, 12'd0,    1'b0, '0}
    };

    // hold reset, then release it on a falling clock edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_setting(cfg_idx_e'(dir_rows[i].a[CfgIdxW-1:0]), dir_rows[i].b);
      end else begin
        send_wakeup(dir_rows[i].a, dir_rows[i].b, dir_rows[i].known, dir_rows[i].want);
      end
    end

    // watering phases, both extremes first
    for (ph = 0; ph < 6; ph++) begin
      drain_results();
      choose_settings(ph == 0 ? SET_TOP : ph == 1 ? SET_BOTTOM : SET_WATERING);
      repeat (25) send_wakeup(pick_soil(), pick_light(), 1'b0, '0);
    end

    // long dry spell with no watering, elapsed time runs into saturation
    for (ph = 0; ph < 8; ph++) begin
      drain_results();
      choose_settings(SET_DRY_SPELL);
      repeat (92) send_wakeup(pick_soil(), pick_light(), 1'b0, '0);
    end

    // catch up after the saturated wait
    for (ph = 0; ph < 2; ph++) begin
      drain_results();
      choose_settings(SET_CATCH_UP);
      repeat (20) send_wakeup(pick_soil(), pick_light(), 1'b0, '0);
    end

    drain_results();
    repeat (24) @(posedge clk_i);

    $display("%0d wake-ups sent, %0d results checked over %0d setting phases",
             wakeups_sent, results_seen, phases_run);
    $display("%0d waterings and %0d low light alarms expected, %0d mismatches",
             waterings_seen, alarms_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
